FILE: rtl/bdpc_pkg.sv
// Shared constants for the button debounce and press classifier.
package bdpc_pkg;

    // Configuration register layout
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_PRESS_MAX  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd15;
    localparam logic [CFG_W-1:0] SHORT_PRESS_MAX_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd5000;

    // Default width of the settle and press timers
    localparam int TIMER_WIDTH_DEF = 16;

    // Stream widths: input carries the pin sample, output the level and four events
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Output tdata bit positions
    localparam int OB_LEVEL   = 0;
    localparam int OB_PRESS   = 1;
    localparam int OB_SHORT   = 2;
    localparam int OB_RELEASE = 3;
    localparam int OB_LONG    = 4;

endpackage

FILE: rtl/button_debounce_press_classifier.sv
// Button debouncer with press, release, short-press and long-press classification.
// The result of each input transfer is registered in the output register.
// Throughput: one tick per clock; a stalled result holds s_tready low until taken.
// State update and classification are one combinational pass between state registers.
// Reset (aresetn low, synchronous): level released, timers cleared, hold disarmed,
// registers back to 15 / 1000 / 5000, no result pending.
module button_debounce_press_classifier #(
    parameter int TIMER_WIDTH = bdpc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bdpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bdpc_pkg::CFG_W-1:0]        cfg_wr_data,
    // input ticks
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bdpc_pkg::S_TDATA_W-1:0]    s_tdata,  // [0] pin_level, [7:1] zero
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] debounced_level, [1] press_event, [2] short_press_event,
    // [3] release_event, [4] long_press_event, [7:5] zero
    output logic [bdpc_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CFG_W = bdpc_pkg::CFG_W;
    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] debounce_ticks_reg;
    logic [CFG_W-1:0] short_press_max_reg;
    logic [CFG_W-1:0] long_press_ticks_reg;

    // tick state
    logic                   raw_follow_reg,   raw_follow_next;
    logic                   settling_reg,     settling_next;
    logic [TIMER_WIDTH-1:0] settle_count_reg, settle_count_next;
    logic                   stable_level_reg, stable_level_next;
    logic [TIMER_WIDTH-1:0] press_count_reg,  press_count_next;
    logic                   hold_armed_reg,   hold_armed_next;

    // output stage
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [bdpc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // combinational pass
    logic                   pin;
    logic                   in_xfer;
    logic                   raw_change;
    logic                   settling_a;
    logic [TIMER_WIDTH-1:0] settle_a;
    logic [TIMER_WIDTH-1:0] press_a;
    logic [TIMER_WIDTH-1:0] press_b;
    logic                   lvl_accept;
    logic                   fell;
    logic                   rose;
    logic                   hold_b;
    logic                   ev_short;
    logic                   ev_long;

    assign pin      = s_tdata[0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= bdpc_pkg::DEBOUNCE_TICKS_RST;
            short_press_max_reg  <= bdpc_pkg::SHORT_PRESS_MAX_RST;
            long_press_ticks_reg <= bdpc_pkg::LONG_PRESS_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bdpc_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wr_data;
                bdpc_pkg::REG_SHORT_PRESS_MAX:  short_press_max_reg  <= cfg_wr_data;
                bdpc_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        raw_change = (pin != raw_follow_reg);
        settling_a = raw_change || settling_reg;

        // settle timer restarts on a change, else counts while settling (saturating)
        if (raw_change) begin
            settle_a = '0;
        end else if (settling_reg && !(&settle_count_reg)) begin
            settle_a = settle_count_reg + TIMER_WIDTH'(1);
        end else begin
            settle_a = settle_count_reg;
        end

        press_a = (&press_count_reg) ? press_count_reg
                                     : press_count_reg + TIMER_WIDTH'(1);

        lvl_accept = settling_a && (CMP_W'(settle_a) >= CMP_W'(debounce_ticks_reg));
        fell       = lvl_accept && stable_level_reg && !pin;
        rose       = lvl_accept && !stable_level_reg && pin;

        press_b  = fell ? '0 : press_a;
        ev_short = rose && (CMP_W'(press_a) <= CMP_W'(short_press_max_reg));

        if (fell) begin
            hold_b = 1'b1;
        end else if (rose) begin
            hold_b = 1'b0;
        end else begin
            hold_b = hold_armed_reg;
        end
        ev_long = hold_b && (CMP_W'(press_b) > CMP_W'(long_press_ticks_reg));

        raw_follow_next   = raw_follow_reg;
        settling_next     = settling_reg;
        settle_count_next = settle_count_reg;
        stable_level_next = stable_level_reg;
        press_count_next  = press_count_reg;
        hold_armed_next   = hold_armed_reg;
        m_tdata_next      = m_tdata_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;

        if (in_xfer) begin
            raw_follow_next   = pin;
            settling_next     = settling_a && !lvl_accept;
            settle_count_next = settle_a;
            stable_level_next = lvl_accept ? pin : stable_level_reg;
            press_count_next  = press_b;
            hold_armed_next   = hold_b && !ev_long;
            m_tvalid_next     = 1'b1;
            m_tdata_next                       = '0;
            m_tdata_next[bdpc_pkg::OB_LEVEL]   = lvl_accept ? pin : stable_level_reg;
            m_tdata_next[bdpc_pkg::OB_PRESS]   = fell;
            m_tdata_next[bdpc_pkg::OB_SHORT]   = ev_short;
            m_tdata_next[bdpc_pkg::OB_RELEASE] = rose;
            m_tdata_next[bdpc_pkg::OB_LONG]    = ev_long;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_follow_reg   <= 1'b1;
            settling_reg     <= 1'b0;
            settle_count_reg <= '0;
            stable_level_reg <= 1'b1;
            press_count_reg  <= '0;
            hold_armed_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            raw_follow_reg   <= raw_follow_next;
            settling_reg     <= settling_next;
            settle_count_reg <= settle_count_next;
            stable_level_reg <= stable_level_next;
            press_count_reg  <= press_count_next;
            hold_armed_reg   <= hold_armed_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // a press event always leaves the level pressed, a release leaves it released
    a_press_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[bdpc_pkg::OB_PRESS] |-> !m_tdata_reg[bdpc_pkg::OB_LEVEL])
        else $error("press event with released level");

    a_release_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[bdpc_pkg::OB_RELEASE] |-> m_tdata_reg[bdpc_pkg::OB_LEVEL])
        else $error("release event with pressed level");

    // short press only comes with a release
    a_short_needs_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[bdpc_pkg::OB_SHORT] |-> m_tdata_reg[bdpc_pkg::OB_RELEASE])
        else $error("short press without release");

    // release disarms hold detection
    a_release_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && rose |=> !hold_armed_reg)
        else $error("hold still armed after release");

    // the result register is held while the sink stalls
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("stalled result changed");
`endif

endmodule
